// ----- hw/rtl/imhi_pkg.sv -----
// ----------------------------------------------------------------------------
// imhi_pkg: shared types for the indexed max-heap insert block
// Holds the sequencer state encoding, the store write controls and the
// fixed width of the reported slot and position fields.
// ----------------------------------------------------------------------------
package imhi_pkg;

  // Reported slot and position are cast to this width
  localparam int OUT_W = 8;

  // Sift-up sequencer, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAP  = 5'b00010,
    S_VAL  = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } imhi_state_t;

  // Write enables toward the heap store
  typedef struct packed {
    logic map_we;
    logic val_we;
  } imhi_wr_t;

endpackage

// ----- hw/rtl/imhi_store.sv -----
// ----------------------------------------------------------------------------
// imhi_store: heap storage
// Position-to-slot map and per-slot value memory, each with one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module imhi_store
  import imhi_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int VW    = 32
) (
  input  logic          clk,
  input  imhi_wr_t      wr,
  input  logic [AW-1:0] map_waddr,
  input  logic [AW-1:0] map_wdata,
  input  logic [AW-1:0] map_raddr,
  output logic [AW-1:0] map_rdata,
  input  logic [AW-1:0] val_waddr,
  input  logic [VW-1:0] val_wdata,
  input  logic [AW-1:0] val_raddr,
  output logic [VW-1:0] val_rdata
);

  logic [AW-1:0] map_mem [DEPTH];
  logic [VW-1:0] val_mem [DEPTH];

  // Position-to-slot map
  always_ff @(posedge clk) begin
    if (wr.map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata <= map_mem[map_raddr];
  end

  // Slot values
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    val_rdata <= val_mem[val_raddr];
  end

endmodule

// ----- hw/rtl/imhi_key_cmp.sv -----
// ----------------------------------------------------------------------------
// imhi_key_cmp: shared order compare
// Flips the sign bit in signed mode so one unsigned compare orders both
// signed and unsigned values; reports parent strictly below new value.
// ----------------------------------------------------------------------------
module imhi_key_cmp #(
  parameter int VW = 32
) (
  input  logic          signed_mode,
  input  logic [VW-1:0] parent_val,
  input  logic [VW-1:0] new_val,
  output logic          less
);

  logic [VW-1:0] flip;
  logic [VW-1:0] parent_key;
  logic [VW-1:0] new_key;

  // Sign flip mask
  assign flip       = {signed_mode, {(VW-1){1'b0}}};
  assign parent_key = parent_val ^ flip;
  assign new_key    = new_val ^ flip;
  assign less       = parent_key < new_key;

endmodule

// ----- hw/rtl/indexed_max_heap_insert.sv -----
// ----------------------------------------------------------------------------
// indexed_max_heap_insert: indexed binary max-heap, insert side
// Inserts values into a max-heap of CAPACITY items by sift-up, returning the
// slot handle used and the value's final heap position, or a full flag.
// ----------------------------------------------------------------------------
// Sequence: on a full heap the result is registered straight from the accepted
//   start; otherwise each level compared takes a map read, a value read and a
//   compare/swap state, then S_DONE writes the store and the result register.
// Throughput: one insert at a time; busy drops as the done strobe goes out,
//   so the next start transfers on the edge that ends the strobe.
// The done strobe lasts one cycle; the receiver cannot stall it.
// Reset: empties the heap and sets signed compare; no clearing pass is needed.
module indexed_max_heap_insert
  import imhi_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   done,
  output logic [OUT_W-1:0]       slot,
  output logic [OUT_W-1:0]       position,
  output logic                   full_res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  imhi_state_t            state;
  imhi_state_t            state_next;
  logic                   signed_compare;
  logic [CW-1:0]          count;
  logic [AW-1:0]          pos;
  logic [AW-1:0]          parent;
  logic [AW-1:0]          here;
  logic [VALUE_WIDTH-1:0] new_val;
  logic                   at_capacity;
  logic                   accept;
  logic                   less;
  imhi_wr_t               wr;
  logic [AW-1:0]          map_waddr;
  logic [AW-1:0]          map_wdata;
  logic [AW-1:0]          map_rdata;
  logic [VALUE_WIDTH-1:0] val_rdata;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_compare <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      signed_compare <= cfg_data;
    end
  end

  // Handshake and derived indices
  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign at_capacity = (count == CW'(CAPACITY));
  assign parent      = AW'((pos - 1'b1) >> 1);
  // Slots are handed out in order, so the item count is the next free slot
  assign here        = count[AW-1:0];

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !at_capacity) begin
          state_next = (count == '0) ? S_DONE : S_MAP;
        end
      end
      S_MAP:  state_next = S_VAL;
      S_VAL:  state_next = S_CMP;
      S_CMP: begin
        state_next = (less && parent != '0) ? S_MAP : S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working position and item count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_DONE) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos     <= count[AW-1:0];
      new_val <= value;
    end else if (state == S_CMP && less) begin
      pos <= parent;
    end
  end

  // Store writes: parent's slot moves down on a swap, new slot lands at its final position
  always_comb begin
    wr.map_we = (state == S_CMP && less) || (state == S_DONE);
    wr.val_we = (state == S_DONE);
    map_waddr = pos;
    map_wdata = (state == S_DONE) ? here : map_rdata;
  end

  imhi_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .VW    (VALUE_WIDTH)
  ) u_store (
    .clk       (clk),
    .wr        (wr),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_raddr (parent),
    .map_rdata (map_rdata),
    .val_waddr (here),
    .val_wdata (new_val),
    .val_raddr (map_rdata),
    .val_rdata (val_rdata)
  );

  imhi_key_cmp #(
    .VW (VALUE_WIDTH)
  ) u_cmp (
    .signed_mode (signed_compare),
    .parent_val  (val_rdata),
    .new_val     (new_val),
    .less        (less)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && at_capacity) || (state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && at_capacity) begin
      slot     <= '0;
      position <= '0;
      full_res <= 1'b1;
    end else if (state == S_DONE) begin
      slot     <= OUT_W'(here);
      position <= OUT_W'(pos);
      full_res <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("item count above capacity");

  a_full_payload : assert property (@(posedge clk) disable iff (rst)
    done && full_res |-> slot == '0 && position == '0)
    else $error("full result carries nonzero slot or position");

  a_pos_bound : assert property (@(posedge clk) disable iff (rst)
    busy |-> {1'b0, pos} <= {1'b0, count})
    else $error("sift position beyond item count");

  a_insert_counts : assert property (@(posedge clk) disable iff (rst)
    done && !full_res |-> count == $past(count) + 1'b1)
    else $error("insert result without count update");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");
`endif

endmodule
